FILE: rtl/hbs_pkg.sv
`default_nettype none

package hbs_pkg;

  // Fixed field widths of the item and configuration channels.
  localparam int OP_W       = 1;
  localparam int IN_CRD_W   = 6;
  localparam int COUNT_W    = 7;
  localparam int RAD_W      = 3;
  localparam int SIZE_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Window coordinates: a clamped center plus the radius must fit.
  localparam int CRD_W = 8;

  localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  // A programmed size of zero acts as one; a size above the limit saturates.
  function automatic logic [CRD_W-1:0] eff_size(logic [SIZE_W-1:0] v, int lim);
    logic [CRD_W-1:0] res;
    if (v == '0) begin
      res = CRD_W'(1);
    end else if (int'(v) > lim) begin
      res = CRD_W'(lim);
    end else begin
      res = CRD_W'(v);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/hbs_grid_mem.sv
`default_nettype none

module hbs_grid_mem #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 24
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/hbs_div.sv
`default_nettype none

module hbs_div #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 7
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic        [DEN_W-1:0] den_i,
  output logic                         done_o,
  output logic signed      [NUM_W-1:0] quot_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic             neg_q;
  logic [NUM_W-1:0] q_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;

  logic [DEN_W:0]   shifted;
  logic             fits;

  // Restoring division on the magnitude, one quotient bit per cycle.
  assign shifted = {rem_q, q_q[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NUM_W-1];
      q_q   <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? DEN_W'(shifted - {1'b0, den_q}) : DEN_W'(shifted);
      q_q   <= {q_q[NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(q_q) : $signed(q_q);

endmodule

`default_nettype wire

FILE: rtl/heightmap_box_smoother.sv
// Write requests produce no result.
// A query covering n window cells makes one grid memory read per cell, then one
// quotient bit per cycle in the divider. One item is in work at a time.
// Reset is asynchronous and active low; it restores the configuration defaults and
// clears control state; the grid memory is not cleared.
`default_nettype none

module heightmap_box_smoother #(
  parameter int MAX_COLS    = 64,
  parameter int MAX_ROWS    = 64,
  parameter int MAX_RADIUS  = 4,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [hbs_pkg::OP_W-1:0]            op_i,
  input  wire logic [hbs_pkg::IN_CRD_W-1:0]        col_i,
  input  wire logic [hbs_pkg::IN_CRD_W-1:0]        row_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       sample_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]            mean_o,
  output logic [hbs_pkg::COUNT_W-1:0]              cell_count_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [hbs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [hbs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import hbs_pkg::*;

  localparam int COL_AW  = $clog2(MAX_COLS);
  localparam int ROW_AW  = $clog2(MAX_ROWS);
  localparam int ADDR_W  = COL_AW + ROW_AW;
  localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CNT_W   = $clog2(WIN_MAX + 1);
  localparam int SUM_W   = SAMPLE_BITS + CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_HOLD  = 3'd5;

  logic [2:0]              state_q, state_d;
  logic [RAD_W-1:0]        radius_q;
  logic [SIZE_W-1:0]       width_q;
  logic [SIZE_W-1:0]       height_q;

  logic [CRD_W-1:0]        w_eff, h_eff, w_last, h_last;
  logic [CRD_W-1:0]        r_eff;
  logic [CRD_W-1:0]        col_ext, row_ext;
  logic [CRD_W-1:0]        cx_q, ry_q;
  logic [CRD_W-1:0]        c0_q, c1_q, r0_q, r1_q;
  logic [CRD_W-1:0]        ci_q, rj_q;
  logic [CRD_W-1:0]        c_lo, c_hi, r_lo, r_hi;
  logic [CRD_W-1:0]        cx_plus, ry_plus;

  logic                    in_acc;
  logic                    mem_we;
  logic                    mem_re;
  logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
  logic [SAMPLE_BITS-1:0]  mem_rdata;
  logic                    rd_pend_q;

  logic signed [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0]        count_q;

  logic                    div_start;
  logic                    div_done;
  logic signed [SUM_W-1:0] div_quot;

  logic                    out_free;
  logic                    out_load;
  logic                    out_valid_q;
  logic [SAMPLE_BITS-1:0]  mean_q;
  logic [COUNT_W-1:0]      cnt_out_q;

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RAD_W'(1);
      width_q  <= SIZE_W'(64);
      height_q <= SIZE_W'(64);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_RADIUS: radius_q <= cfg_data_i[RAD_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff  = eff_size(width_q, MAX_COLS);
  assign h_eff  = eff_size(height_q, MAX_ROWS);
  assign w_last = w_eff - 1'b1;
  assign h_last = h_eff - 1'b1;
  assign r_eff  = (int'(radius_q) > MAX_RADIUS) ? CRD_W'(MAX_RADIUS) : CRD_W'(radius_q);

  // Input side
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign col_ext    = CRD_W'(col_i);
  assign row_ext    = CRD_W'(row_i);

  // Writes outside the grid in use are dropped.
  assign mem_we    = in_acc && (op_i == OP_WRITE) && (col_ext < w_eff) && (row_ext < h_eff);
  assign mem_waddr = {ROW_AW'(row_i), COL_AW'(col_i)};

  // Window bounds, clipped to the grid in use.
  assign cx_plus = cx_q + r_eff;
  assign ry_plus = ry_q + r_eff;
  assign c_lo    = (cx_q > r_eff) ? cx_q - r_eff : '0;
  assign r_lo    = (ry_q > r_eff) ? ry_q - r_eff : '0;
  assign c_hi    = (cx_plus < w_last) ? cx_plus : w_last;
  assign r_hi    = (ry_plus < h_last) ? ry_plus : h_last;

  assign mem_re    = (state_q == S_SCAN);
  assign mem_raddr = {ROW_AW'(rj_q), COL_AW'(ci_q)};

  // The last read returns during the first drain cycle; the divider starts after it.
  assign div_start = (state_q == S_DRAIN) && !rd_pend_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == S_HOLD) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc && (op_i == OP_QUERY)) state_d = S_SETUP;
      S_SETUP: state_d = S_SCAN;
      S_SCAN:  if ((ci_q == c1_q) && (rj_q == r1_q)) state_d = S_DRAIN;
      S_DRAIN: if (div_start) state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_HOLD;
      S_HOLD:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= mem_re;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        // Centers beyond the grid saturate to the last column or row.
        cx_q <= (col_ext >= w_eff) ? w_last : col_ext;
        ry_q <= (row_ext >= h_eff) ? h_last : row_ext;
      end
      S_SETUP: begin
        c0_q <= c_lo;
        c1_q <= c_hi;
        r0_q <= r_lo;
        r1_q <= r_hi;
        ci_q <= c_lo;
        rj_q <= r_lo;
      end
      S_SCAN: begin
        if (ci_q == c1_q) begin
          ci_q <= c0_q;
          if (rj_q != r1_q) begin
            rj_q <= rj_q + 1'b1;
          end
        end else begin
          ci_q <= ci_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SETUP) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (rd_pend_q) begin
      sum_q   <= sum_q + SUM_W'($signed(mem_rdata));
      count_q <= count_q + 1'b1;
    end
  end

  hbs_grid_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (SAMPLE_BITS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (sample_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  hbs_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_q),
    .den_i   (count_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mean_q    <= div_quot[SAMPLE_BITS-1:0];
      cnt_out_q <= COUNT_W'(count_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mean_o       = $signed(mean_q);
  assign cell_count_o = cnt_out_q;

  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == S_IDLE)
    else $error("grid write outside idle");

  a_scan_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> (ci_q >= c0_q) && (ci_q <= c1_q) && (rj_q >= r0_q) && (rj_q <= r1_q))
    else $error("scan position left the window");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (count_q != '0) && (int'(count_q) <= WIN_MAX))
    else $error("cell count out of range at divide");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside divide state");

  a_load_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> $past(state_q) == S_DIV || $past(state_q) == S_HOLD)
    else $error("result loaded without a finished divide");

endmodule

`default_nettype wire

FILE: verif/heightmap_box_smoother_tb.sv
`default_nettype none

module heightmap_box_smoother_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hbs_pkg::*;

  localparam int GRID_COLS     = 64;
  localparam int GRID_ROWS     = 64;
  localparam int RADIUS_CAP    = 4;
  localparam int SETTLE_CYCLES = 150;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 60;
  localparam int REPORT_LINES  = 40;

  localparam logic signed [23:0] H_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] H_MIN = 24'sh800000;

  typedef struct {
    logic signed [23:0] mean;
    logic [COUNT_W-1:0] count;
  } smooth_t;

  typedef enum logic {STEP_ITEM, STEP_REG} step_kind_e;

  typedef struct {
    step_kind_e kind;
    logic [OP_W-1:0] op;
    logic [IN_CRD_W-1:0] col;
    logic [IN_CRD_W-1:0] row;
    logic signed [23:0] sample;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    bit typed;
    smooth_t want;
  } dir_step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [OP_W-1:0] op_i = OP_WRITE;
  logic [IN_CRD_W-1:0] col_i = '0;
  logic [IN_CRD_W-1:0] row_i = '0;
  logic signed [23:0] sample_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [23:0] mean_o;
  logic [COUNT_W-1:0] cell_count_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Shadow copy of the block: grid contents, which cells hold data, and registers.
  logic signed [23:0] grid_m [GRID_COLS*GRID_ROWS];
  bit written_m [GRID_COLS*GRID_ROWS];
  logic [RAD_W-1:0] rad_m;
  logic [SIZE_W-1:0] wid_m;
  logic [SIZE_W-1:0] hgt_m;

  smooth_t pending_means[$];
  int mismatch_cnt = 0;
  bit calm_run = 1'b0;
  int stall_left = 0;
  int sent_items = 0;

  heightmap_box_smoother i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mean_o       (mean_o),
    .cell_count_o (cell_count_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin : watchdog
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_LINES) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic int used_size(input logic [SIZE_W-1:0] v, input int cap);
    if (v == '0) return 1;
    if (int'(v) > cap) return cap;
    return int'(v);
  endfunction

  // Clipped window around the center, after the center is pulled into the grid.
  function automatic void window_bounds(input logic [IN_CRD_W-1:0] col, row,
                                        output int c0, c1, r0, r1);
    int w, h, r, cc, rc;
    w = used_size(wid_m, GRID_COLS);
    h = used_size(hgt_m, GRID_ROWS);
    r = (int'(rad_m) > RADIUS_CAP) ? RADIUS_CAP : int'(rad_m);
    cc = (int'(col) >= w) ? w - 1 : int'(col);
    rc = (int'(row) >= h) ? h - 1 : int'(row);
    c0 = (cc > r) ? cc - r : 0;
    r0 = (rc > r) ? rc - r : 0;
    c1 = (cc + r < w - 1) ? cc + r : w - 1;
    r1 = (rc + r < h - 1) ? rc + r : h - 1;
  endfunction

  function automatic smooth_t smooth_at(input logic [IN_CRD_W-1:0] col, row);
    int c0, c1, r0, r1;
    longint acc, n;
    smooth_t res;
    window_bounds(col, row, c0, c1, r0, r1);
    acc = 0;
    n = 0;
    for (int j = r0; j <= r1; j++) begin
      for (int i = c0; i <= c1; i++) begin
        acc += longint'(grid_m[j*GRID_COLS + i]);
        n++;
      end
    end
    // SystemVerilog division of signed values truncates toward zero.
    res.mean = 24'(acc / n);
    res.count = COUNT_W'(n);
    return res;
  endfunction

  function automatic logic signed [23:0] pick_height();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 15) return H_MAX;
    if (k < 30) return H_MIN;
    if (k < 60) return 24'(int'($urandom_range(0, 1023)) - 512);
    return 24'($urandom);
  endfunction

  function automatic int pick_gap();
    int unsigned k;
    if (calm_run) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_size();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 15) return 64;
    if (k < 22) return 0;
    if (k < 29) return 127;
    if (k < 36) return 1;
    if (k < 80) return $urandom_range(2, 16);
    return $urandom_range(17, 100);
  endfunction

  function automatic dir_step_t mk_step(input step_kind_e kind, input logic [OP_W-1:0] op,
                                        input int col, row, input logic signed [23:0] s,
                                        input logic [CFG_IDX_W-1:0] idx, input int data,
                                        input bit typed, input logic signed [23:0] mean,
                                        input int count);
    dir_step_t st;
    st.kind = kind;
    st.op = op;
    st.col = IN_CRD_W'(col);
    st.row = IN_CRD_W'(row);
    st.sample = s;
    st.idx = idx;
    st.data = CFG_DATA_W'(data);
    st.typed = typed;
    st.want.mean = mean;
    st.want.count = COUNT_W'(count);
    return st;
  endfunction

  function automatic dir_step_t wr(input int col, row, input logic signed [23:0] s);
    return mk_step(STEP_ITEM, OP_WRITE, col, row, s, CFG_RADIUS, 0, 1'b0, '0, 0);
  endfunction

  function automatic dir_step_t qu(input int col, row);
    return mk_step(STEP_ITEM, OP_QUERY, col, row, '0, CFG_RADIUS, 0, 1'b0, '0, 0);
  endfunction

  function automatic dir_step_t qx(input int col, row, input logic signed [23:0] mean,
                                   input int count);
    return mk_step(STEP_ITEM, OP_QUERY, col, row, '0, CFG_RADIUS, 0, 1'b1, mean, count);
  endfunction

  function automatic dir_step_t rg(input logic [CFG_IDX_W-1:0] idx, input int data);
    return mk_step(STEP_REG, OP_WRITE, 0, 0, '0, idx, data, 1'b0, '0, 0);
  endfunction

  // Valid stays high from one accepted request to the next when there is no gap.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IN_CRD_W-1:0] col, row,
                              input logic signed [23:0] s, input bit typed,
                              input smooth_t typed_res, output bit counted);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    col_i <= col;
    row_i <= row;
    sample_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    counted = 1'b1;
    if (op == OP_QUERY) begin
      pending_means.push_back(typed ? typed_res : smooth_at(col, row));
    end else if (int'(col) < used_size(wid_m, GRID_COLS) &&
                 int'(row) < used_size(hgt_m, GRID_ROWS)) begin
      grid_m[int'(row)*GRID_COLS + int'(col)] = s;
      written_m[int'(row)*GRID_COLS + int'(col)] = 1'b1;
    end else begin
      counted = 1'b0;
    end
    if (counted) sent_items++;
  endtask

  // The grid is not cleared at reset, so every cell a query covers is written first.
  task automatic issue_query(input logic [IN_CRD_W-1:0] col, row, input bit typed,
                             input smooth_t typed_res);
    int c0, c1, r0, r1;
    bit counted;
    window_bounds(col, row, c0, c1, r0, r1);
    for (int j = r0; j <= r1; j++) begin
      for (int i = c0; i <= c1; i++) begin
        if (!written_m[j*GRID_COLS + i]) begin
          send_request(OP_WRITE, IN_CRD_W'(i), IN_CRD_W'(j), pick_height(), 1'b0, typed_res,
                       counted);
        end
      end
    end
    send_request(OP_QUERY, col, row, pick_height(), typed, typed_res, counted);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_RADIUS: rad_m = data[RAD_W-1:0];
      CFG_WIDTH:  wid_m = data;
      CFG_HEIGHT: hgt_m = data;
      default: ;
    endcase
    if (last) cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : sink_pace
    int unsigned k;
    if (stall_left > 0) begin
      stall_left--;
    end else if (calm_run) begin
      out_stall_i <= 1'b0;
      stall_left = 16;
    end else begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        out_stall_i <= 1'b0;
        stall_left = $urandom_range(1, 8);
      end else if (k < 90) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(1, 3);
      end else begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(10, 60);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    smooth_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_means.size() == 0) begin
        report_mismatch($sformatf("result mean %0d count %0d with no query pending",
                                  mean_o, cell_count_o));
      end else begin
        want = pending_means.pop_front();
        if (mean_o !== want.mean) begin
          report_mismatch($sformatf("mean got %0d exp %0d", mean_o, want.mean));
        end
        if (cell_count_o !== want.count) begin
          report_mismatch($sformatf("cell_count got %0d exp %0d", cell_count_o, want.count));
        end
      end
    end
  end

  initial begin : stimulus
    dir_step_t steps[$];
    smooth_t none;
    int ph_rad [7];
    int ph_wid [7];
    int ph_hgt [7];
    int rr, ww, hh, wE, hE, pc, pr, c, r, phase_start;
    int unsigned k;
    bit counted, paused;

    none.mean = '0;
    none.count = '0;
    ph_rad = '{4, 0, 2, 3, 5, 1, 4};
    ph_wid = '{64, 1, 64, 7, 127, 0, 12};
    ph_hgt = '{64, 64, 1, 9, 20, 0, 12};
    rad_m = 3'd1;
    wid_m = 7'd64;
    hgt_m = 7'd64;
    foreach (written_m[i]) written_m[i] = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corners at the field extremes, each window clipped to four cells.
    steps.push_back(wr(0, 0, H_MAX));
    steps.push_back(wr(1, 0, H_MAX));
    steps.push_back(wr(0, 1, H_MAX));
    steps.push_back(wr(1, 1, H_MAX));
    steps.push_back(qx(0, 0, H_MAX, 4));
    steps.push_back(wr(63, 63, H_MIN));
    steps.push_back(wr(62, 63, H_MIN));
    steps.push_back(wr(63, 62, H_MIN));
    steps.push_back(wr(62, 62, H_MIN));
    steps.push_back(qx(63, 63, H_MIN, 4));
    // A zero radius reads only the addressed cell.
    steps.push_back(rg(CFG_RADIUS, 0));
    steps.push_back(qx(0, 0, H_MAX, 1));
    steps.push_back(qx(63, 63, H_MIN, 1));
    steps.push_back(wr(5, 5, -24'sd1));
    steps.push_back(qx(5, 5, -24'sd1, 1));
    // On a 2x1 grid a sum of -3 over two cells must give -1, not -2.
    steps.push_back(rg(CFG_RADIUS, 1));
    steps.push_back(rg(CFG_WIDTH, 2));
    steps.push_back(rg(CFG_HEIGHT, 1));
    steps.push_back(wr(0, 0, -24'sd3));
    steps.push_back(wr(1, 0, 24'sd0));
    steps.push_back(qx(0, 0, -24'sd1, 2));
    steps.push_back(qx(63, 63, -24'sd1, 2));
    steps.push_back(wr(1, 5, 24'sd123));
    steps.push_back(qx(1, 0, -24'sd1, 2));
    // Zero sizes act as a single cell.
    steps.push_back(rg(CFG_WIDTH, 0));
    steps.push_back(rg(CFG_HEIGHT, 0));
    steps.push_back(qx(40, 40, -24'sd3, 1));
    // Oversized radius and oversized grid saturate.
    steps.push_back(rg(CFG_RADIUS, 7));
    steps.push_back(rg(CFG_WIDTH, 3));
    steps.push_back(rg(CFG_HEIGHT, 3));
    steps.push_back(qu(1, 1));
    steps.push_back(rg(CFG_WIDTH, 127));
    steps.push_back(rg(CFG_HEIGHT, 127));
    steps.push_back(qu(63, 0));
    steps.push_back(qu(0, 63));

    foreach (steps[s]) begin
      if (steps[s].kind == STEP_REG) begin
        wait_drained();
        write_reg(steps[s].idx, steps[s].data, 1'b1);
      end else if (steps[s].op == OP_WRITE) begin
        send_request(OP_WRITE, steps[s].col, steps[s].row, steps[s].sample, 1'b0, none,
                     counted);
      end else begin
        issue_query(steps[s].col, steps[s].row, steps[s].typed, steps[s].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p < 7) begin
        rr = ph_rad[p];
        ww = ph_wid[p];
        hh = ph_hgt[p];
      end else begin
        rr = $urandom_range(0, 7);
        ww = pick_size();
        hh = pick_size();
      end
      write_reg(CFG_RADIUS, CFG_DATA_W'(rr), 1'b0);
      write_reg(CFG_WIDTH, CFG_DATA_W'(ww), 1'b0);
      write_reg(CFG_HEIGHT, CFG_DATA_W'(hh), 1'b1);
      calm_run = (p % 4 == 3);
      wE = used_size(wid_m, GRID_COLS);
      hE = used_size(hgt_m, GRID_ROWS);
      // Most traffic stays in a small patch so written cells get reused by queries.
      pc = $urandom_range(0, wE - 1);
      pr = $urandom_range(0, hE - 1);
      phase_start = sent_items;
      paused = 1'b0;
      while (sent_items - phase_start < PHASE_ITEMS) begin
        if (p == 6 && !paused && sent_items - phase_start >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        k = $urandom_range(0, 99);
        if (k < 35) begin
          if ($urandom_range(0, 9) < 7) begin
            c = pc + $urandom_range(0, 7);
            r = pr + $urandom_range(0, 7);
            if (c > wE - 1) c = wE - 1;
            if (r > hE - 1) r = hE - 1;
          end else begin
            c = $urandom_range(0, wE - 1);
            r = $urandom_range(0, hE - 1);
          end
          send_request(OP_WRITE, IN_CRD_W'(c), IN_CRD_W'(r), pick_height(), 1'b0, none,
                       counted);
        end else if (k < 45) begin
          // Unrestricted coordinates: writes past the grid in use must be dropped.
          send_request(OP_WRITE, IN_CRD_W'($urandom_range(0, 63)),
                       IN_CRD_W'($urandom_range(0, 63)), pick_height(), 1'b0, none, counted);
        end else begin
          if ($urandom_range(0, 99) < 85) begin
            c = pc + $urandom_range(0, 7);
            r = pr + $urandom_range(0, 7);
            if (c > 63) c = 63;
            if (r > 63) r = 63;
          end else begin
            c = $urandom_range(0, 63);
            r = $urandom_range(0, 63);
          end
          issue_query(IN_CRD_W'(c), IN_CRD_W'(r), 1'b0, none);
        end
      end
    end

    calm_run = 1'b0;
    wait_drained();
    if (mismatch_cnt == 0 && pending_means.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
